### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and disabled during reset
`define FSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled during reset
`define FSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fsr_pkg.sv
`timescale 1ns / 1ps

package fsr_pkg;

  typedef enum logic [3:0] {
    PH_WAIT_START = 4'd0,
    PH_WAIT_ADDR  = 4'd1,
    PH_WAIT_FUNC  = 4'd2,
    PH_READ_DATA  = 4'd3,
    PH_WAIT_CHK   = 4'd4,
    PH_WAIT_STOP  = 4'd5,
    PH_STOP_BAD   = 4'd6,
    PH_DONE       = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ALL   = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PAYLOAD    = 3'd1,
    EV_GOOD_ALL   = 3'd2,
    EV_GOOD_SHORT = 3'd3,
    EV_ERROR      = 3'd4,
    EV_FLUSHED    = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_BROADCAST     = 3'd1,
    ERR_OTHER_ADDR    = 3'd2,
    ERR_BAD_FUNC      = 3'd3,
    ERR_BAD_CHK       = 3'd4,
    ERR_BAD_CHK_NOSTP = 3'd5,
    ERR_NO_STOP       = 3'd6
  } cause_t;

  typedef enum logic [2:0] {
    CHUNK_NOT_END  = 3'd0,
    CHUNK_NO_CTX   = 3'd1,
    CHUNK_PARTIAL  = 3'd2,
    CHUNK_COMPLETE = 3'd3,
    CHUNK_ERROR    = 3'd4
  } chunk_t;

  typedef enum logic [2:0] {
    CFG_START_BYTE = 3'd0,
    CFG_STOP_BYTE  = 3'd1,
    CFG_OWN_ADDR   = 3'd2,
    CFG_BCAST_ADDR = 3'd3,
    CFG_READ_ALL   = 3'd4,
    CFG_READ_STAT  = 3'd5,
    CFG_MIN_LEN    = 3'd6
  } cfg_idx_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned MinLenW  = 6;
  localparam int unsigned CountW   = 9;

  localparam logic [7:0]         ChkSeed      = 8'hff;
  localparam logic [MinLenW-1:0] MinLenReset  = 6'd8;
  localparam logic [CountW-1:0]  CntStatus0   = 9'd3;
  localparam logic [CountW-1:0]  CntStatus1   = 9'd4;
  localparam logic [CountW-1:0]  CntLength    = 9'd5;
  localparam logic [9:0]         HeaderOffset = 10'd3;

  typedef struct packed {
    logic [7:0]         start_byte;
    logic [7:0]         stop_byte;
    logic [7:0]         own_address;
    logic [7:0]         broadcast_address;
    logic [7:0]         read_all_code;
    logic [7:0]         read_status_code;
    logic [MinLenW-1:0] min_frame_length;
  } cfg_t;

  typedef struct packed {
    event_t     ev;
    cause_t     cause;
    logic [7:0] payload_byte;
    logic [7:0] status_low;
    logic       status_flag;
    logic [5:0] feeder_code;
    logic [7:0] payload_length;
    chunk_t     chunk;
    logic [3:0] prior_phase;
  } result_t;

endpackage

### src/fsr_cfg.sv
`timescale 1ns / 1ps

module fsr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fsr_pkg::CfgDataW-1:0] cfg_wdata,
  output fsr_pkg::cfg_t                cfg
);

  fsr_pkg::cfg_t cfg_r;
  fsr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fsr_pkg::CFG_START_BYTE: cfg_nxt.start_byte        = cfg_wdata;
        fsr_pkg::CFG_STOP_BYTE:  cfg_nxt.stop_byte         = cfg_wdata;
        fsr_pkg::CFG_OWN_ADDR:   cfg_nxt.own_address       = cfg_wdata;
        fsr_pkg::CFG_BCAST_ADDR: cfg_nxt.broadcast_address = cfg_wdata;
        fsr_pkg::CFG_READ_ALL:   cfg_nxt.read_all_code     = cfg_wdata;
        fsr_pkg::CFG_READ_STAT:  cfg_nxt.read_status_code  = cfg_wdata;
        fsr_pkg::CFG_MIN_LEN: begin
          cfg_nxt.min_frame_length = cfg_wdata[fsr_pkg::MinLenW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all codes zero, minimum frame length at its reset value
      cfg_r <= {{6{8'h00}}, fsr_pkg::MinLenReset};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/fsr_core.sv
`timescale 1ns / 1ps

module fsr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             op_flush,
  input  logic [7:0]       rx_byte,
  input  logic             eoc,
  input  fsr_pkg::cfg_t    cfg,
  output fsr_pkg::result_t res
);

  fsr_pkg::phase_t             phase_r, phase_nxt;
  logic [fsr_pkg::CountW-1:0]  count_r, count_nxt;
  logic [7:0]                  chk_r, chk_nxt;
  fsr_pkg::kind_t              kind_r, kind_nxt;
  logic [7:0]                  len_r, len_nxt;
  logic [7:0]                  stat0_r, stat0_nxt;
  logic [7:0]                  stat1_r, stat1_nxt;
  logic                        disc_r, disc_nxt;

  // per-byte decode shared by next-state and result logic
  fsr_pkg::phase_t ph_mid;
  fsr_pkg::kind_t  kind_mid;
  logic [7:0]      len_mid;
  logic [7:0]      stat0_mid;
  logic [7:0]      stat1_mid;
  logic            clear_mid;
  logic            err;
  fsr_pkg::cause_t cause;
  fsr_pkg::event_t ev_mid;
  logic            active_mid;
  logic [9:0]      end_lhs;
  logic [9:0]      end_rhs;

  always_comb begin
    ph_mid    = phase_r;
    kind_mid  = kind_r;
    len_mid   = len_r;
    stat0_mid = stat0_r;
    stat1_mid = stat1_r;
    clear_mid = 1'b0;
    err       = 1'b0;
    cause     = fsr_pkg::ERR_NONE;
    ev_mid    = fsr_pkg::EV_NONE;
    end_lhs   = {1'b0, count_r} + fsr_pkg::HeaderOffset;
    end_rhs   = {4'b0, cfg.min_frame_length} + {2'b0, len_r};
    case (phase_r)
      fsr_pkg::PH_WAIT_START: begin
        if (rx_byte == cfg.start_byte) ph_mid = fsr_pkg::PH_WAIT_ADDR;
      end
      fsr_pkg::PH_WAIT_ADDR: begin
        if (rx_byte == cfg.own_address) begin
          ph_mid = fsr_pkg::PH_WAIT_FUNC;
        end else if (rx_byte == cfg.broadcast_address) begin
          err   = 1'b1;
          cause = fsr_pkg::ERR_BROADCAST;
        end else begin
          err   = 1'b1;
          cause = fsr_pkg::ERR_OTHER_ADDR;
        end
      end
      fsr_pkg::PH_WAIT_FUNC: begin
        if (rx_byte == cfg.read_all_code) begin
          ph_mid   = fsr_pkg::PH_READ_DATA;
          kind_mid = fsr_pkg::KIND_ALL;
        end else if (rx_byte == cfg.read_status_code) begin
          ph_mid   = fsr_pkg::PH_WAIT_CHK;
          kind_mid = fsr_pkg::KIND_SHORT;
        end else begin
          err   = 1'b1;
          cause = fsr_pkg::ERR_BAD_FUNC;
        end
      end
      fsr_pkg::PH_READ_DATA: begin
        if (count_r == fsr_pkg::CntStatus0) begin
          stat0_mid = rx_byte;
        end else if (count_r == fsr_pkg::CntStatus1) begin
          stat1_mid = rx_byte;
        end else begin
          if (count_r == fsr_pkg::CntLength) begin
            len_mid = rx_byte;
            end_rhs = {4'b0, cfg.min_frame_length} + {2'b0, rx_byte};
          end else begin
            ev_mid = fsr_pkg::EV_PAYLOAD;
          end
          if (end_lhs >= end_rhs) ph_mid = fsr_pkg::PH_WAIT_CHK;
        end
      end
      fsr_pkg::PH_WAIT_CHK: begin
        ph_mid = (rx_byte == chk_r) ? fsr_pkg::PH_WAIT_STOP : fsr_pkg::PH_STOP_BAD;
      end
      fsr_pkg::PH_STOP_BAD: begin
        err   = 1'b1;
        cause = (rx_byte == cfg.stop_byte) ? fsr_pkg::ERR_BAD_CHK
                                           : fsr_pkg::ERR_BAD_CHK_NOSTP;
      end
      fsr_pkg::PH_WAIT_STOP: begin
        if (rx_byte == cfg.stop_byte) begin
          ev_mid = (kind_r == fsr_pkg::KIND_ALL) ? fsr_pkg::EV_GOOD_ALL
                                                 : fsr_pkg::EV_GOOD_SHORT;
          ph_mid = fsr_pkg::PH_DONE;
        end else begin
          err   = 1'b1;
          cause = fsr_pkg::ERR_NO_STOP;
        end
      end
      fsr_pkg::PH_DONE: ;
      default: begin
        ph_mid    = fsr_pkg::PH_WAIT_START;
        clear_mid = 1'b1;
      end
    endcase
    active_mid = (ph_mid != fsr_pkg::PH_WAIT_START) && (ph_mid != fsr_pkg::PH_DONE);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    chk_nxt   = chk_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    stat0_nxt = stat0_r;
    stat1_nxt = stat1_r;
    disc_nxt  = disc_r;
    if (step_en) begin
      if (op_flush || (!disc_r && (err || clear_mid ||
          (eoc && ph_mid == fsr_pkg::PH_DONE)))) begin
        phase_nxt = fsr_pkg::PH_WAIT_START;
        count_nxt = '0;
        chk_nxt   = fsr_pkg::ChkSeed;
        kind_nxt  = fsr_pkg::KIND_NONE;
        len_nxt   = '0;
        stat0_nxt = '0;
        stat1_nxt = '0;
        disc_nxt  = !op_flush && err && !eoc;
      end else if (disc_r) begin
        if (eoc) disc_nxt = 1'b0;
      end else begin
        phase_nxt = ph_mid;
        kind_nxt  = kind_mid;
        len_nxt   = len_mid;
        stat0_nxt = stat0_mid;
        stat1_nxt = stat1_mid;
        if (active_mid) begin
          count_nxt = count_r + fsr_pkg::CountW'(1);
          chk_nxt   = chk_r ^ rx_byte;
        end
      end
    end
  end

  // result word
  always_comb begin
    res = '0;
    if (op_flush) begin
      res.ev          = fsr_pkg::EV_FLUSHED;
      res.prior_phase = phase_r;
    end else if (disc_r) begin
      if (eoc) res.chunk = fsr_pkg::CHUNK_ERROR;
    end else if (err) begin
      res.ev    = fsr_pkg::EV_ERROR;
      res.cause = cause;
      if (eoc) res.chunk = fsr_pkg::CHUNK_ERROR;
    end else begin
      res.ev = ev_mid;
      if (ev_mid == fsr_pkg::EV_PAYLOAD) res.payload_byte = rx_byte;
      if (ev_mid == fsr_pkg::EV_GOOD_ALL) begin
        res.status_low     = stat0_r;
        res.status_flag    = stat1_r[0];
        res.feeder_code    = stat1_r[6:1];
        res.payload_length = len_r;
      end
      if (eoc) begin
        if (ph_mid == fsr_pkg::PH_WAIT_START) res.chunk = fsr_pkg::CHUNK_NO_CTX;
        else if (ph_mid == fsr_pkg::PH_DONE)  res.chunk = fsr_pkg::CHUNK_COMPLETE;
        else                                  res.chunk = fsr_pkg::CHUNK_PARTIAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fsr_pkg::PH_WAIT_START;
      count_r <= '0;
      chk_r   <= fsr_pkg::ChkSeed;
      kind_r  <= fsr_pkg::KIND_NONE;
      len_r   <= '0;
      stat0_r <= '0;
      stat1_r <= '0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      chk_r   <= chk_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      stat0_r <= stat0_nxt;
      stat1_r <= stat1_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

### src/framed_serial_receiver_unit.sv
`timescale 1ns / 1ps

// Framed serial receiver. Takes one word (a received byte or a flush) per clock while in_stall
// is low and returns exactly one result word for each, in order. A word passes an input
// register, then the frame decoder (phase, byte count, running xor checksum seeded with 0xff)
// updates its state and loads the result register, which presents the result; one word per
// cycle is sustained while out_stall is low. out_stall, with a valid result, holds the result
// register and, through in_stall, the input register; the pipeline resumes at full rate once
// out_stall drops. Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should only change while no word is in flight.

`include "assert_macros.svh"

module framed_serial_receiver_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fsr_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [7:0]                   in_rx_byte,
  input  logic                         in_end_of_chunk,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_event_res,
  output logic [2:0]                   out_error_cause,
  output logic [7:0]                   out_payload_byte,
  output logic [7:0]                   out_status_low,
  output logic                         out_status_flag,
  output logic [5:0]                   out_feeder_code,
  output logic [7:0]                   out_payload_length,
  output logic [2:0]                   out_chunk_status,
  output logic [3:0]                   out_prior_phase
);

  fsr_pkg::cfg_t    cfg;
  fsr_pkg::result_t core_res;
  fsr_pkg::result_t res_r;

  logic       adv;
  logic       step_en;
  logic       in_valid_r;
  logic       op_r;
  logic [7:0] byte_r;
  logic       eoc_r;
  logic       out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign step_en  = adv && in_valid_r;

  fsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .op_flush (op_r),
    .rx_byte  (byte_r),
    .eoc      (eoc_r),
    .cfg      (cfg),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r  <= in_valid;
      out_valid_r <= in_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      op_r   <= in_op;
      byte_r <= in_rx_byte;
      eoc_r  <= in_end_of_chunk;
    end
    if (step_en) begin
      res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = res_r.ev;
  assign out_error_cause    = res_r.cause;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_status_low     = res_r.status_low;
  assign out_status_flag    = res_r.status_flag;
  assign out_feeder_code    = res_r.feeder_code;
  assign out_payload_length = res_r.payload_length;
  assign out_chunk_status   = res_r.chunk;
  assign out_prior_phase    = res_r.prior_phase;

  `FSR_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid_r && out_stall,
                  "stall without a blocked result")
  `FSR_ASSERT_IMP(a_cause_iff_error,
                  out_valid_r && (out_event_res != fsr_pkg::EV_ERROR),
                  out_error_cause == fsr_pkg::ERR_NONE, "error cause on a non-error word")
  `FSR_ASSERT_IMP(a_phase_only_on_flush,
                  out_valid_r && (out_event_res != fsr_pkg::EV_FLUSHED),
                  out_prior_phase == 4'd0, "prior phase on a non-flush word")
  `FSR_ASSERT_NXT(a_result_follows_input, in_valid_r && adv, out_valid_r,
                  "accepted word produced no result")

endmodule
